// ----- hdl/hrl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hrl_pkg;

    localparam int KEY_W    = 128;
    localparam int HALF_W   = 64;
    localparam int NODE_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 3'd0,
        ST_ID_CONFLICT    = 3'd1,
        ST_RANGE_CONFLICT = 3'd2,
        ST_RING_EMPTY     = 3'd3,
        ST_TABLE_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        SM_IDLE,
        SM_SCAN,
        SM_SHIFT,
        SM_PICK,
        SM_FINISH
    } t_state;

    // replica read steps: issue primary, issue secondary, issue tertiary, take tertiary
    typedef enum logic [1:0] {
        PK_PRI,
        PK_SEC,
        PK_TER,
        PK_LAST
    } t_pick;

    typedef struct packed {
        logic gt;        // entry start above key
        logic eq_start;  // entry start equals key
        logic eq_id;     // entry owner equals id
    } t_cmp;

endpackage

`default_nettype wire

// ----- hdl/hash_ring_replica_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Consistent hash ring lookup with three replicas. The block holds up to MAX_NODES ring
// entries (128-bit start, node id) in one memory sorted by unsigned start. An insert
// (i_cmd 0) scans every entry with one shared comparator for an id conflict, a start
// conflict (reporting the owner) and the insert position, then, if neither conflict
// is found and the table is not full, moves the higher entries up one slot, one entry
// per cycle through the single memory port, and writes the new entry. A lookup (i_cmd 1)
// scans for the first start above the key (secondary, wrapping to entry 0), then reads
// the primary (one before, wrapping), secondary and tertiary (one after, wrapping)
// owners. One command is worked at a time; o_ready is high only between commands, and
// a finished result waits in the output register while the next command is taken. Node
// ids are kept in their low ID_BITS bits (at most 16). The table starts empty after
// reset; no clearing pass is needed.
module hash_ring_replica_lookup #(
    parameter int MAX_NODES = 64,
    parameter int ID_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [63:0] i_key_high,
    input  wire logic [63:0] i_key_low,
    input  wire logic [15:0] i_node_ident,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_primary_node,
    output logic [15:0]      o_secondary_node,
    output logic [15:0]      o_tertiary_node,
    output logic [15:0]      o_conflict_owner
);

    // stored id width: ids arrive on a 16-bit port
    localparam int ID_W = (ID_BITS < hrl_pkg::NODE_W) ? ID_BITS : hrl_pkg::NODE_W;
    localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int DW   = hrl_pkg::KEY_W + ID_W;

    // control state
    hrl_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // working registers
    logic                       r_cmd, n_cmd;
    logic [hrl_pkg::KEY_W-1:0]  r_key, n_key;
    logic [ID_W-1:0]            r_id, n_id;
    logic [CW-1:0]              r_issue, n_issue;   // next entry to read (scan up, move down)
    logic                       r_pend, n_pend;     // read data valid this cycle
    logic [AW-1:0]              r_pidx, n_pidx;     // entry the read data belongs to
    logic                       r_id_hit, n_id_hit;
    logic                       r_rng_hit, n_rng_hit;
    logic [ID_W-1:0]            r_cown, n_cown;
    logic [CW-1:0]              r_pos, n_pos;       // entries at or below the key
    logic                       r_found, n_found;
    logic [AW-1:0]              r_s, n_s;
    hrl_pkg::t_pick             r_pick, n_pick;
    hrl_pkg::t_status           r_status, n_status;
    logic [ID_W-1:0]            r_pri, n_pri;
    logic [ID_W-1:0]            r_sec, n_sec;
    logic [ID_W-1:0]            r_ter, n_ter;

    // output registers
    hrl_pkg::t_status           r_o_status, n_o_status;
    logic [ID_W-1:0]            r_o_pri, n_o_pri;
    logic [ID_W-1:0]            r_o_sec, n_o_sec;
    logic [ID_W-1:0]            r_o_ter, n_o_ter;
    logic [ID_W-1:0]            r_o_cown, n_o_cown;

    // memory and compare unit
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DW-1:0]         w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [DW-1:0]         w_rdata;
    logic [ID_W-1:0]       w_rd_owner;
    hrl_pkg::t_cmp         w_cmp;

    // replica indexes
    logic [CW-1:0]         w_issue_m1;
    logic [AW-1:0]         w_sec_idx;
    logic [AW-1:0]         w_pri_idx;
    logic [AW-1:0]         w_ter_idx;
    logic [CW-1:0]         w_last;
    logic [CW-1:0]         w_sec_p1;

    assign w_rd_owner = w_rdata[ID_W-1:0];

    hrl_mem #(
        .DEPTH (MAX_NODES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hrl_cmp #(
        .ID_W (ID_W)
    ) u_cmp (
        .i_start (w_rdata[DW-1:ID_W]),
        .i_key   (r_key),
        .i_owner (w_rd_owner),
        .i_id    (r_id),
        .o_res   (w_cmp)
    );

    // secondary wraps to entry 0 when no start lies above the key
    assign w_issue_m1 = r_issue - CW'(1);
    assign w_sec_idx  = r_found ? r_s : '0;
    assign w_last     = r_count - CW'(1);
    assign w_sec_p1   = CW'(w_sec_idx) + CW'(1);
    assign w_pri_idx  = (w_sec_idx == '0) ? w_last[AW-1:0] : (w_sec_idx - AW'(1));
    assign w_ter_idx  = (w_sec_p1 >= r_count) ? '0 : w_sec_p1[AW-1:0];

    // sequencer: next state, datapath updates, memory port
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_id        = r_id;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_id_hit    = r_id_hit;
        n_rng_hit   = r_rng_hit;
        n_cown      = r_cown;
        n_pos       = r_pos;
        n_found     = r_found;
        n_s         = r_s;
        n_pick      = r_pick;
        n_status    = r_status;
        n_pri       = r_pri;
        n_sec       = r_sec;
        n_ter       = r_ter;
        n_o_status  = r_o_status;
        n_o_pri     = r_o_pri;
        n_o_sec     = r_o_sec;
        n_o_ter     = r_o_ter;
        n_o_cown    = r_o_cown;
        w_we        = 1'b0;
        w_waddr     = r_pidx + AW'(1);
        w_wdata     = w_rdata;
        w_raddr     = '0;

        // result leaves on its transfer
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            hrl_pkg::SM_IDLE: begin
                if (i_valid) begin
                    n_cmd     = i_cmd;
                    n_key     = {i_key_high, i_key_low};
                    n_id      = i_node_ident[ID_W-1:0];
                    n_issue   = '0;
                    n_id_hit  = 1'b0;
                    n_rng_hit = 1'b0;
                    n_cown    = '0;
                    n_pos     = '0;
                    n_found   = 1'b0;
                    n_s       = '0;
                    n_pick    = hrl_pkg::PK_PRI;
                    n_status  = hrl_pkg::ST_OK;
                    n_pri     = '0;
                    n_sec     = '0;
                    n_ter     = '0;
                    if (i_cmd == hrl_pkg::CMD_LOOKUP && r_count == '0) begin
                        n_status = hrl_pkg::ST_RING_EMPTY;
                        n_state  = hrl_pkg::SM_FINISH;
                    end else begin
                        n_state = hrl_pkg::SM_SCAN;
                    end
                end
            end

            hrl_pkg::SM_SCAN: begin
                w_raddr = r_issue[AW-1:0];
                if (r_issue < r_count) begin
                    n_issue = r_issue + CW'(1);
                    n_pend  = 1'b1;
                    n_pidx  = r_issue[AW-1:0];
                end
                // evaluate the entry read last cycle
                if (r_pend) begin
                    if (r_cmd == hrl_pkg::CMD_INSERT) begin
                        if (w_cmp.eq_id) begin
                            n_id_hit = 1'b1;
                        end
                        if (w_cmp.eq_start) begin
                            n_rng_hit = 1'b1;
                            n_cown    = w_rd_owner;
                        end
                        if (!w_cmp.gt) begin
                            n_pos = r_pos + CW'(1);
                        end
                    end else if (w_cmp.gt && !r_found) begin
                        n_found = 1'b1;
                        n_s     = r_pidx;
                    end
                end
                if (r_issue == r_count && !r_pend) begin
                    if (r_cmd == hrl_pkg::CMD_LOOKUP) begin
                        n_state = hrl_pkg::SM_PICK;
                    end else if (r_id_hit) begin
                        n_status = hrl_pkg::ST_ID_CONFLICT;
                        n_cown   = '0;
                        n_state  = hrl_pkg::SM_FINISH;
                    end else if (r_rng_hit) begin
                        n_status = hrl_pkg::ST_RANGE_CONFLICT;
                        n_state  = hrl_pkg::SM_FINISH;
                    end else if (32'(r_count) >= 32'(MAX_NODES)) begin
                        n_status = hrl_pkg::ST_TABLE_FULL;
                        n_state  = hrl_pkg::SM_FINISH;
                    end else begin
                        n_issue = r_count;
                        n_state = hrl_pkg::SM_SHIFT;
                    end
                end
            end

            hrl_pkg::SM_SHIFT: begin
                // move entries from the top down to the insert position, one per cycle
                w_raddr = w_issue_m1[AW-1:0];
                if (r_issue > r_pos) begin
                    n_issue = w_issue_m1;
                    n_pend  = 1'b1;
                    n_pidx  = w_issue_m1[AW-1:0];
                end
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = r_pidx + AW'(1);
                    w_wdata = w_rdata;
                end else if (r_issue == r_pos) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[AW-1:0];
                    w_wdata = {r_key, r_id};
                    n_count = r_count + CW'(1);
                    n_state = hrl_pkg::SM_FINISH;
                end
            end

            hrl_pkg::SM_PICK: begin
                case (r_pick)
                    hrl_pkg::PK_PRI: begin
                        w_raddr = w_pri_idx;
                        n_pick  = hrl_pkg::PK_SEC;
                    end
                    hrl_pkg::PK_SEC: begin
                        w_raddr = w_sec_idx;
                        n_pri   = w_rd_owner;
                        n_pick  = hrl_pkg::PK_TER;
                    end
                    hrl_pkg::PK_TER: begin
                        w_raddr = w_ter_idx;
                        n_sec   = w_rd_owner;
                        n_pick  = hrl_pkg::PK_LAST;
                    end
                    hrl_pkg::PK_LAST: begin
                        n_ter   = w_rd_owner;
                        n_state = hrl_pkg::SM_FINISH;
                    end
                    default: begin
                        n_pick = hrl_pkg::PK_PRI;
                    end
                endcase
            end

            hrl_pkg::SM_FINISH: begin
                // hand over once the output register is free or being emptied
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_pri     = r_pri;
                    n_o_sec     = r_sec;
                    n_o_ter     = r_ter;
                    n_o_cown    = r_cown;
                    n_state     = hrl_pkg::SM_IDLE;
                end
            end

            default: begin
                n_state = hrl_pkg::SM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrl_pkg::SM_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_id       <= n_id;
        r_issue    <= n_issue;
        r_pidx     <= n_pidx;
        r_id_hit   <= n_id_hit;
        r_rng_hit  <= n_rng_hit;
        r_cown     <= n_cown;
        r_pos      <= n_pos;
        r_found    <= n_found;
        r_s        <= n_s;
        r_pick     <= n_pick;
        r_status   <= n_status;
        r_pri      <= n_pri;
        r_sec      <= n_sec;
        r_ter      <= n_ter;
        r_o_status <= n_o_status;
        r_o_pri    <= n_o_pri;
        r_o_sec    <= n_o_sec;
        r_o_ter    <= n_o_ter;
        r_o_cown   <= n_o_cown;
    end

    assign o_ready          = (r_state == hrl_pkg::SM_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_o_status;
    assign o_primary_node   = hrl_pkg::NODE_W'(r_o_pri);
    assign o_secondary_node = hrl_pkg::NODE_W'(r_o_sec);
    assign o_tertiary_node  = hrl_pkg::NODE_W'(r_o_ter);
    assign o_conflict_owner = hrl_pkg::NODE_W'(r_o_cown);

`ifndef NO_ASSERTIONS
    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_NODES))
        else $error("entry count above capacity");

    // the table grows by exactly one entry per successful insert
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) && $past(r_state) == hrl_pkg::SM_SHIFT))
        else $error("entry count changed outside an insert");

    // the table is written only while moving entries, never beyond the stored count
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == hrl_pkg::SM_SHIFT && CW'(w_waddr) <= r_count))
        else $error("table write outside the move window");
`endif

endmodule

`default_nettype wire

// ----- hdl/hrl_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrl_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 144
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/hrl_cmp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrl_cmp #(
    parameter int ID_W = 16
) (
    input  wire logic [hrl_pkg::KEY_W-1:0] i_start,
    input  wire logic [hrl_pkg::KEY_W-1:0] i_key,
    input  wire logic [ID_W-1:0]           i_owner,
    input  wire logic [ID_W-1:0]           i_id,
    output hrl_pkg::t_cmp                  o_res
);

    // single 128-bit unsigned magnitude compare shared by every scan
    always_comb begin
        o_res.gt       = (i_start > i_key);
        o_res.eq_start = (i_start == i_key);
        o_res.eq_id    = (i_owner == i_id);
    end

endmodule

`default_nettype wire

// ----- tb/sv/hrl_checker.sv -----
`timescale 1ns / 1ps

// watches both channels of the ring lookup, keeps a shadow copy of the ring
// and compares every result transfer with the oldest predicted answer
module hrl_checker #(
    parameter int MAX_NODES = 64,
    parameter int ID_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic        i_cmd,
    input  logic [63:0] i_key_high,
    input  logic [63:0] i_key_low,
    input  logic [15:0] i_node_ident,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_primary_node,
    input  logic [15:0] i_secondary_node,
    input  logic [15:0] i_tertiary_node,
    input  logic [15:0] i_conflict_owner,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [15:0] ID_MASK = 16'((32'd1 << ID_BITS) - 1);

    typedef struct packed {
        hrl_pkg::t_status status;
        logic [15:0]      primary;
        logic [15:0]      secondary;
        logic [15:0]      tertiary;
        logic [15:0]      owner;
    } t_replica_answer;

    logic [127:0]    ring_start [MAX_NODES];
    logic [15:0]     ring_owner [MAX_NODES];
    int              ring_size = 0;
    t_replica_answer answers_due [$];
    int              mismatches = 0;
    t_replica_answer due_ans;
    t_replica_answer seen_ans;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // applies one command to the shadow ring and returns the answer it must give
    task automatic apply_ring_command(input logic cmd, input logic [127:0] key,
                                      input logic [15:0] ident_in,
                                      output t_replica_answer ans);
        logic [15:0] ident;
        int          idx;
        int          slot;
        int          sec_idx;
        bit          settled;
        ident   = ident_in & ID_MASK;
        ans     = '0;
        ans.status = hrl_pkg::ST_OK;
        settled = 1'b0;
        if (cmd == hrl_pkg::CMD_INSERT) begin
            for (idx = 0; idx < ring_size && !settled; idx++) begin
                if (ring_owner[idx] == ident) begin
                    ans.status = hrl_pkg::ST_ID_CONFLICT;
                    settled    = 1'b1;
                end
            end
            for (idx = 0; idx < ring_size && !settled; idx++) begin
                if (ring_start[idx] == key) begin
                    ans.status = hrl_pkg::ST_RANGE_CONFLICT;
                    ans.owner  = ring_owner[idx];
                    settled    = 1'b1;
                end
            end
            if (!settled && ring_size >= MAX_NODES) begin
                ans.status = hrl_pkg::ST_TABLE_FULL;
                settled    = 1'b1;
            end
            if (!settled) begin
                slot = ring_size;
                while (slot > 0 && ring_start[slot-1] > key) begin
                    ring_start[slot] = ring_start[slot-1];
                    ring_owner[slot] = ring_owner[slot-1];
                    slot--;
                end
                ring_start[slot] = key;
                ring_owner[slot] = ident;
                ring_size++;
            end
        end else if (ring_size == 0) begin
            ans.status = hrl_pkg::ST_RING_EMPTY;
        end else begin
            // first start strictly above the key, wrapping to the lowest start
            sec_idx = ring_size;
            for (idx = 0; idx < ring_size && sec_idx == ring_size; idx++) begin
                if (ring_start[idx] > key) sec_idx = idx;
            end
            if (sec_idx == ring_size) sec_idx = 0;
            ans.primary   = ring_owner[(sec_idx == 0) ? ring_size - 1 : sec_idx - 1];
            ans.secondary = ring_owner[sec_idx];
            ans.tertiary  = ring_owner[(sec_idx + 1 == ring_size) ? 0 : sec_idx + 1];
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_size = 0;
            answers_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                seen_ans = {i_status, i_primary_node, i_secondary_node,
                            i_tertiary_node, i_conflict_owner};
                if (answers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing outstanding: status %0d",
                                 $time, i_status);
                end else begin
                    due_ans = answers_due.pop_front();
                    if (seen_ans.status !== due_ans.status ||
                        seen_ans.primary !== due_ans.primary ||
                        seen_ans.secondary !== due_ans.secondary ||
                        seen_ans.tertiary !== due_ans.tertiary ||
                        seen_ans.owner !== due_ans.owner) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected %0d %h %h %h %h, got %0d %h %h %h %h",
                                     $time, due_ans.status, due_ans.primary,
                                     due_ans.secondary, due_ans.tertiary, due_ans.owner,
                                     seen_ans.status, seen_ans.primary,
                                     seen_ans.secondary, seen_ans.tertiary, seen_ans.owner);
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                apply_ring_command(i_cmd, {i_key_high, i_key_low}, i_node_ident, due_ans);
                answers_due.push_back(due_ans);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= answers_due.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// stimulus and verdict for the hash ring replica lookup; all prediction and
// comparison lives in hrl_checker, which sits beside the block on both channels
module tb_top;

    localparam int MAX_NODES    = 64;
    localparam int ID_BITS      = 16;
    localparam int RANDOM_ITEMS = 1430;
    localparam int TAIL_ITEMS   = 200;     // final stretch with no idling on either side
    localparam int PAUSE_AT     = 700;     // sender holds off here until no result is outstanding
    localparam int GROW_ITEMS   = 600;     // insert-heavy opening so the table fills
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 900_000;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_cmd        = hrl_pkg::CMD_INSERT;
    logic [63:0] i_key_high   = '0;
    logic [63:0] i_key_low    = '0;
    logic [15:0] i_node_ident = '0;
    logic        i_ready      = 1'b0;

    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [15:0] o_primary_node;
    logic [15:0] o_secondary_node;
    logic [15:0] o_tertiary_node;
    logic [15:0] o_conflict_owner;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // idling controls, set by the stimulus and read by the result side
    bit quiet_tail  = 1'b0;
    bit sender_gaps = 1'b1;
    int ready_burst = 0;
    bit ready_stall = 1'b0;

    // starts and ids already offered, reused to provoke conflicts and boundary keys
    logic [127:0] offered_starts [$];
    logic [15:0]  offered_idents [$];

    int item;
    int insert_pct;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    hash_ring_replica_lookup #(
        .MAX_NODES (MAX_NODES),
        .ID_BITS   (ID_BITS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_key_high       (i_key_high),
        .i_key_low        (i_key_low),
        .i_node_ident     (i_node_ident),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_primary_node   (o_primary_node),
        .o_secondary_node (o_secondary_node),
        .o_tertiary_node  (o_tertiary_node),
        .o_conflict_owner (o_conflict_owner)
    );

    hrl_checker #(
        .MAX_NODES (MAX_NODES),
        .ID_BITS   (ID_BITS)
    ) ring_watch (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (i_valid),
        .i_cmd_ready      (o_ready),
        .i_cmd            (i_cmd),
        .i_key_high       (i_key_high),
        .i_key_low        (i_key_low),
        .i_node_ident     (i_node_ident),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_status         (o_status),
        .i_primary_node   (o_primary_node),
        .i_secondary_node (o_secondary_node),
        .i_tertiary_node  (o_tertiary_node),
        .i_conflict_owner (o_conflict_owner),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // result side: random bursts of stall and of ready, a stall burst chosen about one
    // time in three; the tail of the run keeps ready high throughout
    always @(posedge i_clk) begin
        if (ready_burst == 0) begin
            ready_stall = !quiet_tail && ($urandom_range(0, 2) == 0);
            ready_burst = ready_stall ? $urandom_range(1, 7) : $urandom_range(1, 40);
        end
        ready_burst--;
        i_ready <= !ready_stall || quiet_tail;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("hash_ring_replica_lookup verification failed");
        $finish;
    end

    function automatic logic [127:0] random_wide();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // keys cluster around starts already offered so lookups hit range edges
    function automatic logic [127:0] pick_key();
        logic [127:0] base;
        int           mode;
        logic         flip;
        mode = $urandom_range(0, 9);
        flip = 1'($urandom_range(0, 1));
        if (offered_starts.size() == 0) begin
            base = '0;
            if (mode >= 3 && mode <= 6) mode = 0;
        end else begin
            base = offered_starts[$urandom_range(0, offered_starts.size() - 1)];
        end
        case (mode)
            0, 1, 2: return random_wide();
            // one below, equal to, or one above an existing start
            3: return base + 128'($urandom_range(0, 2)) - 128'd1;
            4, 5: return base;
            // same upper half, so only the lower half decides the order
            6: return {base[127:64], $urandom, $urandom};
            7: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return {64'd1, 64'd0};
                    default: return {1'b1, 127'd0};
                endcase
            end
            default: return {{64{flip}}, $urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_ident();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 2 && offered_idents.size() != 0)
            return offered_idents[$urandom_range(0, offered_idents.size() - 1)];
        if (mode == 2) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom);
    endfunction

    // holds valid and payload until the transfer, then maybe leaves a gap
    task automatic send_cmd(input logic cmd, input logic [127:0] key,
                            input logic [15:0] ident);
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_key_high   <= key[127:64];
        i_key_low    <= key[63:0];
        i_node_ident <= ident;
        do @(posedge i_clk); while (!o_ready);
        if (!quiet_tail && sender_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_insert(input logic [127:0] key, input logic [15:0] ident);
        offered_starts.push_back(key);
        offered_idents.push_back(ident);
        send_cmd(hrl_pkg::CMD_INSERT, key, ident);
    endtask

    // sender goes quiet until every outstanding result has been transferred
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lookups on the empty ring
        send_cmd(hrl_pkg::CMD_LOOKUP, '0, 16'h0000);
        send_cmd(hrl_pkg::CMD_LOOKUP, '1, 16'hFFFF);
        // ring of one: all three replicas name the same node
        send_insert('0, 16'h0000);
        send_cmd(hrl_pkg::CMD_LOOKUP, '0, 16'h0000);
        send_cmd(hrl_pkg::CMD_LOOKUP, '1, 16'h0000);
        // ring of two at the extremes of the key space
        send_insert('1, 16'hFFFF);
        send_cmd(hrl_pkg::CMD_LOOKUP, '0, 16'h5A5A);
        send_cmd(hrl_pkg::CMD_LOOKUP, '1, 16'hA5A5);
        // id and start both taken: id conflict wins
        send_insert('0, 16'h0000);
        // start taken under a new id: range conflict names the owner
        send_insert('0, 16'h1234);
        send_insert('1, 16'h1234);
        // starts that differ only in one half
        send_insert({64'd1, 64'd0}, 16'h8000);
        send_insert({64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 16'h0001);
        send_insert({64'h8000_0000_0000_0000, 64'd0}, 16'h00FF);
        // key equal to a start goes to the next start up
        send_cmd(hrl_pkg::CMD_LOOKUP, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 16'h0000);
        send_cmd(hrl_pkg::CMD_LOOKUP, {64'd0, 64'hFFFF_FFFF_FFFF_FFFE}, 16'h0000);
        send_cmd(hrl_pkg::CMD_LOOKUP, {64'd1, 64'd0}, 16'h0000);
        send_cmd(hrl_pkg::CMD_LOOKUP,
                 {64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 16'hFFFF);
        send_insert(random_wide(), 16'h0001);
        send_cmd(hrl_pkg::CMD_LOOKUP, random_wide(), 16'hFFFF);

        // random part: inserts are frequent early so the table fills and the
        // table-full path is exercised for most of the run
        for (item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % 60 == 0) sender_gaps = ($urandom_range(0, 2) != 0);
            if (item == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            if (item == PAUSE_AT) wait_for_drain();
            insert_pct = (item < GROW_ITEMS) ? 20 : 8;
            if ($urandom_range(0, 99) < insert_pct)
                send_insert(pick_key(), pick_ident());
            else
                send_cmd(hrl_pkg::CMD_LOOKUP, pick_key(), 16'($urandom));
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("hash_ring_replica_lookup verification clean");
        end else begin
            $display("hash_ring_replica_lookup verification failed");
        end
        $finish;
    end

endmodule
